FILE: hw/rtl/rpdi_pkg.sv
package rpdi_pkg;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_GCD
  } op_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
  } cmd_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [31:0] value;
  } rsp_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_GCD,
    U_DONE
  } ustate_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_MULD,
    S_RED,
    S_RED_G,
    S_RED_N,
    S_RED_D,
    S_RET,
    S_TERM,
    S_POW_N,
    S_POW_D,
    S_TN,
    S_TD,
    S_AF_G,
    S_AF_FA,
    S_AF_FB,
    S_AF_L,
    S_AF_S1,
    S_AF_S2,
    S_AF_ADD,
    S_FAULT,
    S_FINISH,
    S_FIN,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_COEF,
    PH_TERM,
    PH_SUM
  } phase_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [1:0] CFG_UPPER_NUMER = 2'd0;
  localparam logic [1:0] CFG_UPPER_DENOM = 2'd1;
  localparam logic [1:0] CFG_LOWER_NUMER = 2'd2;
  localparam logic [1:0] CFG_LOWER_DENOM = 2'd3;

  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

endpackage

FILE: hw/rtl/rpdi_serial_unit.sv
module rpdi_serial_unit
  import rpdi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output rsp_t rsp
);

  ustate_t     state, state_next;
  op_t         op_q;
  logic        sgn;
  logic [63:0] acc;
  logic [63:0] mcand;
  logic [31:0] mb;
  logic [31:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic [31:0] gx, gy, gres;
  logic [4:0]  gk;
  logic [31:0] ma, mbi;
  logic [32:0] trial;

  assign ma    = cmd.a[31] ? 32'(-cmd.a) : cmd.a;
  assign mbi   = cmd.b[31] ? 32'(-cmd.b) : cmd.b;
  assign trial = {rem[31:0], quo[31]};

  always_comb begin
    state_next = state;
    unique case (state)
      U_IDLE: begin
        if (cmd.start) begin
          unique case (cmd.op)
            OP_MUL:  state_next = U_MUL;
            OP_DIV:  state_next = U_DIV;
            OP_GCD:  state_next = U_GCD;
            default: state_next = U_DONE;
          endcase
        end
      end
      U_MUL:  if (mb == '0) state_next = U_DONE;
      U_DIV:  if (cnt == 5'd31) state_next = U_DONE;
      U_GCD:  if (gx == '0 || gy == '0) state_next = U_DONE;
      U_DONE: state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one bit of multiplier, quotient or gcd reduction per cycle
  always_ff @(posedge clk) begin
    unique case (state)
      U_IDLE: begin
        if (cmd.start) begin
          op_q  <= cmd.op;
          sgn   <= (cmd.op == OP_MUL) ? (cmd.a[31] ^ cmd.b[31]) : cmd.a[31];
          acc   <= '0;
          mcand <= {32'd0, ma};
          mb    <= mbi;
          quo   <= ma;
          rem   <= '0;
          dvs   <= mbi;
          cnt   <= '0;
          gx    <= ma;
          gy    <= mbi;
          gk    <= '0;
        end
      end
      U_MUL: begin
        if (mb != '0) begin
          if (mb[0]) acc <= acc + mcand;
          mcand <= {mcand[62:0], 1'b0};
          mb    <= {1'b0, mb[31:1]};
        end
      end
      U_DIV: begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
      end
      U_GCD: begin
        priority if (gx == '0 || gy == '0) begin
          gres <= (gx | gy) << gk;
        end else if (!gx[0] && !gy[0]) begin
          gx <= {1'b0, gx[31:1]};
          gy <= {1'b0, gy[31:1]};
          gk <= gk + 5'd1;
        end else if (!gx[0]) begin
          gx <= {1'b0, gx[31:1]};
        end else if (!gy[0]) begin
          gy <= {1'b0, gy[31:1]};
        end else if (gx >= gy) begin
          gx <= (gx - gy) >> 1;
        end else begin
          gy <= (gy - gx) >> 1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp.done  = (state == U_DONE);
    rsp.ovf   = 1'b0;
    rsp.value = '0;
    unique case (op_q)
      OP_MUL: begin
        rsp.ovf   = sgn ? (acc > 64'h0000_0000_8000_0000) : (acc > 64'h0000_0000_7FFF_FFFF);
        rsp.value = sgn ? 32'(-acc[31:0]) : acc[31:0];
      end
      OP_DIV:  rsp.value = sgn ? 32'(-quo) : quo;
      OP_GCD:  rsp.value = gres;
      default: rsp.value = '0;
    endcase
  end

endmodule

FILE: hw/rtl/rational_polynomial_definite_integral_unit.sv
// Exact definite integral of a polynomial with rational coefficients. Each input word carries
// one coefficient n/d of x^power; the block adds n/(d*(power+1)) * x^(power+1) evaluated at the
// configured upper and lower bounds into two reduced fractions, and on a word with tlast set it
// returns upper minus lower as a reduced fraction with positive denominator, status in tuser
// (0 ok, 1 overflow past 32-bit signed, 2 zero denominator; on error the value is 0/1). One item
// at a time runs through a single shared serial unit that multiplies, divides or takes a binary
// gcd one bit per cycle; a multiply stops once no set bits of its second operand remain. Write
// bounds only while the block is idle.
module rational_polynomial_definite_integral_unit
  import rpdi_pkg::*;
#(
  parameter int MAX_POWER = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // coef_numer[31:0], coef_denom[63:32], power[67:64], zero pad
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // result_numer[31:0], result_denom[62:32], zero pad
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  state_t      state, state_next;
  phase_t      phase;
  cmd_t        cmd;
  rsp_t        rsp;
  logic        pend;
  logic [31:0] ub_n, lb_n;
  logic [30:0] ub_d, lb_d;
  logic [31:0] n, d, bn, bd, pn, pd, wn, wd, g, fa, fb, s, l, tmp;
  logic [31:0] an, ad, tn, td, nun, nud;
  logic [31:0] usn, usd, lsn, lsd;
  logic [3:0]  p;
  logic [4:0]  cnt;
  logic        last_q, side, fin;
  logic [1:0]  err;
  logic        unit_state;
  logic        bad_power;
  logic [32:0] sum33;

  assign unit_state = (state == S_MULD)  || (state == S_RED_G) || (state == S_RED_N) ||
                      (state == S_RED_D) || (state == S_POW_N) || (state == S_POW_D) ||
                      (state == S_TN)    || (state == S_TD)    || (state == S_AF_G)  ||
                      (state == S_AF_FA) || (state == S_AF_FB) || (state == S_AF_L)  ||
                      (state == S_AF_S1) || (state == S_AF_S2);
  assign bad_power  = (int'(p) > MAX_POWER);
  assign sum33      = {s[31], s} + {tmp[31], tmp};

  rpdi_serial_unit u_unit (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  always_comb begin
    cmd.start = unit_state && !pend;
    cmd.op    = OP_MUL;
    cmd.a     = '0;
    cmd.b     = '0;
    unique case (state)
      S_MULD:  begin cmd.a = d;  cmd.b = 32'({1'b0, p} + 5'd1); end
      S_RED_G: begin cmd.op = OP_GCD; cmd.a = wn; cmd.b = wd; end
      S_RED_N: begin cmd.op = OP_DIV; cmd.a = wn; cmd.b = g; end
      S_RED_D: begin cmd.op = OP_DIV; cmd.a = wd; cmd.b = g; end
      S_POW_N: begin cmd.a = pn; cmd.b = bn; end
      S_POW_D: begin cmd.a = pd; cmd.b = bd; end
      S_TN:    begin cmd.a = n;  cmd.b = pn; end
      S_TD:    begin cmd.a = d;  cmd.b = pd; end
      S_AF_G:  begin cmd.op = OP_GCD; cmd.a = ad; cmd.b = td; end
      S_AF_FA: begin cmd.op = OP_DIV; cmd.a = td; cmd.b = g; end
      S_AF_FB: begin cmd.op = OP_DIV; cmd.a = ad; cmd.b = g; end
      S_AF_L:  begin cmd.a = ad; cmd.b = fa; end
      S_AF_S1: begin cmd.a = an; cmd.b = fa; end
      S_AF_S2: begin cmd.a = tn; cmd.b = fb; end
      default: ;
    endcase
    s_tready = (state == S_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_CHECK;
      S_CHECK: begin
        priority if (err != ST_OK) state_next = S_FINISH;
        else if (d == '0 || ub_d == '0 || lb_d == '0) state_next = S_FINISH;
        else if (bad_power) state_next = S_FAULT;
        else if (d[31] && (n == WORD_MIN || d == WORD_MIN)) state_next = S_FAULT;
        else state_next = S_MULD;
      end
      S_MULD, S_POW_N, S_TN, S_TD, S_AF_L, S_AF_S1, S_AF_S2: begin
        if (rsp.done) begin
          priority if (rsp.ovf) state_next = S_FAULT;
          else begin
            unique case (state)
              S_MULD:  state_next = S_RED;
              S_POW_N: state_next = S_POW_D;
              S_TN:    state_next = S_TD;
              S_TD:    state_next = S_RED;
              S_AF_L:  state_next = S_AF_S1;
              S_AF_S1: state_next = S_AF_S2;
              default: state_next = S_AF_ADD;
            endcase
          end
        end
      end
      S_POW_D: begin
        if (rsp.done) begin
          priority if (rsp.ovf) state_next = S_FAULT;
          else if (cnt == 5'd1) state_next = S_TN;
          else state_next = S_POW_N;
        end
      end
      S_RED:   state_next = (wn == '0) ? S_RET : S_RED_G;
      S_RED_G: if (rsp.done) state_next = S_RED_N;
      S_RED_N: if (rsp.done) state_next = S_RED_D;
      S_RED_D: if (rsp.done) state_next = S_RET;
      S_RET: begin
        unique case (phase)
          PH_COEF: state_next = S_TERM;
          PH_TERM: state_next = S_AF_G;
          default: begin
            priority if (fin) state_next = S_EMIT;
            else if (!side) state_next = S_TERM;
            else state_next = S_FINISH;
          end
        endcase
      end
      S_TERM:   state_next = S_POW_N;
      S_AF_G:   if (rsp.done) state_next = S_AF_FA;
      S_AF_FA:  if (rsp.done) state_next = S_AF_FB;
      S_AF_FB:  if (rsp.done) state_next = S_AF_L;
      S_AF_ADD: state_next = (sum33[32] != sum33[31]) ? S_FAULT : S_RED;
      S_FAULT:  state_next = fin ? S_EMIT : S_FINISH;
      S_FINISH: begin
        priority if (!last_q) state_next = S_IDLE;
        else if (err != ST_OK) state_next = S_EMIT;
        else state_next = S_FIN;
      end
      S_FIN:    state_next = (lsn == WORD_MIN) ? S_FAULT : S_AF_G;
      S_EMIT:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pend     <= 1'b0;
      err      <= ST_OK;
      fin      <= 1'b0;
      usn      <= '0;
      usd      <= 32'd1;
      lsn      <= '0;
      lsd      <= 32'd1;
      ub_n     <= '0;
      ub_d     <= 31'd1;
      lb_n     <= '0;
      lb_d     <= 31'd1;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.start) pend <= 1'b1;
      else if (rsp.done) pend <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_UPPER_NUMER: ub_n <= cfg_data;
          CFG_UPPER_DENOM: ub_d <= cfg_data[30:0];
          CFG_LOWER_NUMER: lb_n <= cfg_data;
          CFG_LOWER_DENOM: lb_d <= cfg_data[30:0];
          default: ;
        endcase
      end

      // in S_EMIT the output word is reloaded below instead
      if (m_tvalid && m_tready && state != S_EMIT) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            n      <= s_tdata[31:0];
            d      <= s_tdata[63:32];
            p      <= s_tdata[67:64];
            last_q <= s_tlast;
          end
        end
        S_CHECK: begin
          if (err == ST_OK && (d == '0 || ub_d == '0 || lb_d == '0)) err <= ST_ZERO;
          if (d[31]) begin
            n <= 32'(-n);
            d <= 32'(-d);
          end
        end
        S_MULD: begin
          if (rsp.done) begin
            wn    <= n;
            wd    <= rsp.value;
            phase <= PH_COEF;
          end
        end
        S_RED:   if (wn == '0) wd <= 32'd1;
        S_RED_G: if (rsp.done) g <= rsp.value;
        S_RED_N: if (rsp.done) wn <= rsp.value;
        S_RED_D: if (rsp.done) wd <= rsp.value;
        S_RET: begin
          unique case (phase)
            PH_COEF: begin
              n    <= wn;
              d    <= wd;
              side <= 1'b0;
            end
            PH_TERM: begin
              tn <= wn;
              td <= wd;
              an <= side ? lsn : usn;
              ad <= side ? lsd : usd;
            end
            default: begin
              if (!fin) begin
                if (!side) begin
                  nun  <= wn;
                  nud  <= wd;
                  side <= 1'b1;
                end else begin
                  // commit both sums only when neither side faulted
                  usn <= nun;
                  usd <= nud;
                  lsn <= wn;
                  lsd <= wd;
                end
              end
            end
          endcase
        end
        S_TERM: begin
          bn  <= side ? lb_n : ub_n;
          bd  <= side ? {1'b0, lb_d} : {1'b0, ub_d};
          pn  <= 32'd1;
          pd  <= 32'd1;
          cnt <= {1'b0, p} + 5'd1;
        end
        S_POW_N: if (rsp.done) pn <= rsp.value;
        S_POW_D: begin
          if (rsp.done) begin
            pd  <= rsp.value;
            cnt <= cnt - 5'd1;
          end
        end
        S_TN: if (rsp.done) wn <= rsp.value;
        S_TD: begin
          if (rsp.done) begin
            wd    <= rsp.value;
            phase <= PH_TERM;
          end
        end
        S_AF_G:  if (rsp.done) g <= rsp.value;
        S_AF_FA: if (rsp.done) fa <= rsp.value;
        S_AF_FB: if (rsp.done) fb <= rsp.value;
        S_AF_L:  if (rsp.done) l <= rsp.value;
        S_AF_S1: if (rsp.done) s <= rsp.value;
        S_AF_S2: if (rsp.done) tmp <= rsp.value;
        S_AF_ADD: begin
          wn    <= sum33[31:0];
          wd    <= l;
          phase <= PH_SUM;
        end
        S_FAULT: if (err == ST_OK) err <= ST_OVF;
        S_FINISH: if (last_q) fin <= 1'b1;
        S_FIN: begin
          an <= usn;
          ad <= usd;
          tn <= 32'(-lsn);
          td <= lsd;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= err;
            if (err != ST_OK) begin
              m_tdata <= {1'b0, 31'd1, 32'd0};
            end else begin
              m_tdata <= {1'b0, wd[30:0], wn};
            end
            usn <= '0;
            usd <= 32'd1;
            lsn <= '0;
            lsd <= 32'd1;
            err <= ST_OK;
            fin <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_usd_pos: assert property (@(posedge clk) disable iff (rst)
    !usd[31] && usd != '0) else $error("upper sum denominator not positive");
  a_lsd_pos: assert property (@(posedge clk) disable iff (rst)
    !lsd[31] && lsd != '0) else $error("lower sum denominator not positive");
  a_err_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == {1'b0, 31'd1, 32'd0})
    else $error("error result not 0/1");
  a_err_keep: assert property (@(posedge clk) disable iff (rst)
    $past(err) == ST_ZERO && !$past(rst) |-> err == ST_ZERO || err == ST_OK)
    else $error("zero-denominator status lost");
  a_unit_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !pend) else $error("item taken while unit busy");
`endif

endmodule
